// ===== rtl/dalt_pkg.sv =====
// dalt_pkg: shared types, register map and reset values for the light tracker core
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package dalt_pkg;

    localparam int PULSE_W = 15;
    localparam int LIGHT_W = 12;
    localparam int STEP_W  = 11;
    localparam int DELAY_W = 3;
    localparam int OP_W    = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // opcodes
    localparam logic [OP_W-1:0] OP_SAMPLE   = 3'd0;
    localparam logic [OP_W-1:0] OP_JOG_X_DN = 3'd1;
    localparam logic [OP_W-1:0] OP_JOG_X_UP = 3'd2;
    localparam logic [OP_W-1:0] OP_JOG_Y_DN = 3'd3;
    localparam logic [OP_W-1:0] OP_JOG_Y_UP = 3'd4;
    localparam logic [OP_W-1:0] OP_HOME     = 3'd5;

    // register indexes
    localparam logic [2:0] REG_X_MIN  = 3'd0;
    localparam logic [2:0] REG_X_MAX  = 3'd1;
    localparam logic [2:0] REG_Y_MIN  = 3'd2;
    localparam logic [2:0] REG_Y_MAX  = 3'd3;
    localparam logic [2:0] REG_X_HOME = 3'd4;
    localparam logic [2:0] REG_Y_HOME = 3'd5;
    localparam logic [2:0] REG_DEAD   = 3'd6;
    localparam logic [2:0] REG_JOG    = 3'd7;

    // reset values
    localparam logic [PULSE_W-1:0] X_MIN_RST  = 15'd500;
    localparam logic [PULSE_W-1:0] X_MAX_RST  = 15'd2500;
    localparam logic [PULSE_W-1:0] Y_MIN_RST  = 15'd500;
    localparam logic [PULSE_W-1:0] Y_MAX_RST  = 15'd2500;
    localparam logic [PULSE_W-1:0] X_HOME_RST = 15'd1500;
    localparam logic [PULSE_W-1:0] Y_HOME_RST = 15'd1000;
    localparam logic [LIGHT_W-1:0] DEAD_RST   = 12'd100;
    localparam logic [STEP_W-1:0]  JOG_RST    = 11'd50;

    // light difference bands
    localparam logic [LIGHT_W-1:0] BAND_HIGH = 12'd500;
    localparam logic [LIGHT_W-1:0] BAND_MID  = 12'd200;
    localparam logic [STEP_W-1:0]  STEP_FAST = 11'd50;
    localparam logic [STEP_W-1:0]  STEP_MID  = 11'd20;
    localparam logic [STEP_W-1:0]  STEP_FINE = 11'd5;
    localparam logic [DELAY_W-1:0] DELAY_NONE = 3'd0;
    localparam logic [DELAY_W-1:0] DELAY_FAST = 3'd2;
    localparam logic [DELAY_W-1:0] DELAY_MID  = 3'd3;
    localparam logic [DELAY_W-1:0] DELAY_FINE = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [LIGHT_W-1:0] left_light;
        logic [LIGHT_W-1:0] right_light;
        logic [LIGHT_W-1:0] up_light;
        logic [LIGHT_W-1:0] down_light;
    } req_t;

    typedef struct packed {
        logic [PULSE_W-1:0] x_pulse_out;
        logic [PULSE_W-1:0] y_pulse_out;
        logic [STEP_W-1:0]  step_used;
        logic [DELAY_W-1:0] delay_code;
        logic               x_moved;
        logic               y_moved;
        logic               limit_alarm;
    } result_t;

    typedef struct packed {
        logic [PULSE_W-1:0] x_min_pulse;
        logic [PULSE_W-1:0] x_max_pulse;
        logic [PULSE_W-1:0] y_min_pulse;
        logic [PULSE_W-1:0] y_max_pulse;
        logic [PULSE_W-1:0] x_home_pulse;
        logic [PULSE_W-1:0] y_home_pulse;
        logic [LIGHT_W-1:0] dead_band;
        logic [STEP_W-1:0]  jog_step;
    } cfg_t;

endpackage

// ===== rtl/dalt_cfg_regs.sv =====
// dalt_cfg_regs: apb register file holding servo limits, home positions, dead band and jog step
// depends on dalt_pkg
`timescale 1ns / 1ps

module dalt_cfg_regs
    import dalt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_X_MIN:  cfg_next.x_min_pulse  = pwdata[PULSE_W-1:0];
                REG_X_MAX:  cfg_next.x_max_pulse  = pwdata[PULSE_W-1:0];
                REG_Y_MIN:  cfg_next.y_min_pulse  = pwdata[PULSE_W-1:0];
                REG_Y_MAX:  cfg_next.y_max_pulse  = pwdata[PULSE_W-1:0];
                REG_X_HOME: cfg_next.x_home_pulse = pwdata[PULSE_W-1:0];
                REG_Y_HOME: cfg_next.y_home_pulse = pwdata[PULSE_W-1:0];
                REG_DEAD:   cfg_next.dead_band    = pwdata[LIGHT_W-1:0];
                REG_JOG:    cfg_next.jog_step     = pwdata[STEP_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min_pulse  <= X_MIN_RST;
            cfg_reg.x_max_pulse  <= X_MAX_RST;
            cfg_reg.y_min_pulse  <= Y_MIN_RST;
            cfg_reg.y_max_pulse  <= Y_MAX_RST;
            cfg_reg.x_home_pulse <= X_HOME_RST;
            cfg_reg.y_home_pulse <= Y_HOME_RST;
            cfg_reg.dead_band    <= DEAD_RST;
            cfg_reg.jog_step     <= JOG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_X_MIN:  prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_reg.x_min_pulse};
            REG_X_MAX:  prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_reg.x_max_pulse};
            REG_Y_MIN:  prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_reg.y_min_pulse};
            REG_Y_MAX:  prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_reg.y_max_pulse};
            REG_X_HOME: prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_reg.x_home_pulse};
            REG_Y_HOME: prdata = {{(DATA_W-PULSE_W){1'b0}}, cfg_reg.y_home_pulse};
            REG_DEAD:   prdata = {{(DATA_W-LIGHT_W){1'b0}}, cfg_reg.dead_band};
            REG_JOG:    prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_reg.jog_step};
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== rtl/dalt_step_logic.sv =====
// dalt_step_logic: combinational servo update for one request: band select, move and clamp
// depends on dalt_pkg
`timescale 1ns / 1ps

module dalt_step_logic
    import dalt_pkg::*;
(
    input  cfg_t               cfg,
    input  req_t               req,
    input  logic [PULSE_W-1:0] x_pulse,
    input  logic [PULSE_W-1:0] y_pulse,
    output result_t            result
);

    function automatic logic [PULSE_W-1:0] move_up(
        input logic [PULSE_W-1:0] p,
        input logic [STEP_W-1:0]  step,
        input logic [PULSE_W-1:0] hi
    );
        logic [PULSE_W:0] n;
        n = {1'b0, p} + {{(PULSE_W+1-STEP_W){1'b0}}, step};
        if (p >= hi)
            return p;
        else if (n > {1'b0, hi})
            return hi;
        else
            return n[PULSE_W-1:0];
    endfunction

    function automatic logic [PULSE_W-1:0] move_down(
        input logic [PULSE_W-1:0] p,
        input logic [STEP_W-1:0]  step,
        input logic [PULSE_W-1:0] lo
    );
        logic [PULSE_W-1:0] s;
        logic [PULSE_W-1:0] n;
        s = {{(PULSE_W-STEP_W){1'b0}}, step};
        n = (p > s) ? (p - s) : '0;
        if (p <= lo)
            return p;
        else if (n < lo)
            return lo;
        else
            return n;
    endfunction

    logic [LIGHT_W-1:0] dx;
    logic [LIGHT_W-1:0] dy;
    logic [STEP_W-1:0]  band_step;
    logic [DELAY_W-1:0] band_delay;
    logic [PULSE_W-1:0] x_new;
    logic [PULSE_W-1:0] y_new;

    always_comb
    begin
        dx = (req.left_light > req.right_light) ? (req.left_light - req.right_light)
                                                : (req.right_light - req.left_light);
        dy = (req.up_light > req.down_light) ? (req.up_light - req.down_light)
                                             : (req.down_light - req.up_light);
        if (dx > BAND_HIGH || dy > BAND_HIGH)
        begin
            band_step  = STEP_FAST;
            band_delay = DELAY_FAST;
        end
        else if (dx > BAND_MID || dy > BAND_MID)
        begin
            band_step  = STEP_MID;
            band_delay = DELAY_MID;
        end
        else
        begin
            band_step  = STEP_FINE;
            band_delay = DELAY_FINE;
        end
    end

    always_comb
    begin
        x_new             = x_pulse;
        y_new             = y_pulse;
        result.step_used  = '0;
        result.delay_code = DELAY_NONE;
        unique case (req.opcode)
            OP_SAMPLE:
            begin
                result.step_used  = band_step;
                result.delay_code = band_delay;
                if (dx > cfg.dead_band)
                begin
                    if (req.left_light > req.right_light)
                        x_new = move_up(x_pulse, band_step, cfg.x_max_pulse);
                    else if (req.left_light < req.right_light)
                        x_new = move_down(x_pulse, band_step, cfg.x_min_pulse);
                end
                if (dy > cfg.dead_band)
                begin
                    if (req.up_light > req.down_light)
                        y_new = move_up(y_pulse, band_step, cfg.y_max_pulse);
                    else if (req.up_light < req.down_light)
                        y_new = move_down(y_pulse, band_step, cfg.y_min_pulse);
                end
            end
            OP_JOG_X_DN:
            begin
                result.step_used  = cfg.jog_step;
                result.delay_code = DELAY_FAST;
                x_new = move_down(x_pulse, cfg.jog_step, cfg.x_min_pulse);
            end
            OP_JOG_X_UP:
            begin
                result.step_used  = cfg.jog_step;
                result.delay_code = DELAY_FAST;
                x_new = move_up(x_pulse, cfg.jog_step, cfg.x_max_pulse);
            end
            OP_JOG_Y_DN:
            begin
                result.step_used  = cfg.jog_step;
                result.delay_code = DELAY_FAST;
                y_new = move_down(y_pulse, cfg.jog_step, cfg.y_min_pulse);
            end
            OP_JOG_Y_UP:
            begin
                result.step_used  = cfg.jog_step;
                result.delay_code = DELAY_FAST;
                y_new = move_up(y_pulse, cfg.jog_step, cfg.y_max_pulse);
            end
            OP_HOME:
            begin
                x_new = cfg.x_home_pulse;
                y_new = cfg.y_home_pulse;
            end
            // unused codes leave the pulses alone
            default:
            begin
                x_new = x_pulse;
                y_new = y_pulse;
            end
        endcase
        result.x_pulse_out = x_new;
        result.y_pulse_out = y_new;
        result.x_moved     = (x_new != x_pulse);
        result.y_moved     = (y_new != y_pulse);
        result.limit_alarm = (x_new == cfg.x_min_pulse) || (x_new == cfg.x_max_pulse) ||
                             (y_new == cfg.y_min_pulse) || (y_new == cfg.y_max_pulse);
    end

endmodule

// ===== rtl/dual_axis_light_tracker_servo_control_core.sv =====
// channel   direction  handshake                      payload
// req       in         req_valid / req_ready          req (req_t)
// result    out        result_valid / result_ready    result (result_t)
// apb       in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// one request per cycle sustained while results are taken; a taken request goes into the input register
// at the accepting edge, then through the servo update into the result register
// the pulse state updates as a request moves into the result register, so requests chain
// with no gap; a stalled result holds one request in the input register, then req_ready drops
// reset is asynchronous, active low: both registers empty, pulses at home, registers at defaults
`timescale 1ns / 1ps

module dual_axis_light_tracker_servo_control_core
    import dalt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t               cfg;
    logic               in_valid_reg;
    req_t               in_data_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;
    result_t            step_result;
    logic [PULSE_W-1:0] x_pulse_reg;
    logic [PULSE_W-1:0] y_pulse_reg;
    logic               can_load;
    logic               fire;

    dalt_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dalt_step_logic u_step (
        .cfg     (cfg),
        .req     (in_data_reg),
        .x_pulse (x_pulse_reg),
        .y_pulse (y_pulse_reg),
        .result  (step_result)
    );

    assign can_load     = !out_valid_reg || result_ready;
    assign fire         = in_valid_reg && can_load;
    assign req_ready    = !in_valid_reg || fire;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            x_pulse_reg   <= X_HOME_RST;
            y_pulse_reg   <= Y_HOME_RST;
        end
        else
        begin
            if (req_ready)
                in_valid_reg <= req_valid;
            if (can_load)
                out_valid_reg <= in_valid_reg;
            if (fire)
            begin
                x_pulse_reg <= step_result.x_pulse_out;
                y_pulse_reg <= step_result.y_pulse_out;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            in_data_reg <= req;
        if (fire)
            out_data_reg <= step_result;
    end

endmodule

// ===== rtl/dalt_checker.sv =====
// dalt_checker: port-level checks for the light tracker core, bound to the top level
// depends on dalt_pkg and dual_axis_light_tracker_servo_control_core
`timescale 1ns / 1ps

module dalt_checker
    import dalt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_ready,
    input logic              result_valid,
    input logic              result_ready,
    input result_t           result
);

    // a stalled result keeps its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // requests are held off only when a result waits
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> result_valid && !result_ready)
        else $error("req_ready low without a stalled result");

    // fine and mid bands carry their own step
    a_band_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.delay_code != DELAY_FINE || result.step_used == STEP_FINE) &&
                         (result.delay_code != DELAY_MID || result.step_used == STEP_MID))
        else $error("band step and delay code disagree");

    // home and unused codes carry no step
    a_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.delay_code == DELAY_NONE |-> result.step_used == '0)
        else $error("step reported without a delay code");

endmodule

bind dual_axis_light_tracker_servo_control_core dalt_checker u_dalt_checker (.*);

// ===== tb/sv/tb_dual_axis_light_tracker_servo_control_core.sv =====
// testbench for the dual-axis light tracker core: random and directed requests, apb setup
// writes, an in-bench servo predictor and a field-by-field result check
// depends on dalt_pkg and the core rtl only
`timescale 1ns / 1ps

module tb_dual_axis_light_tracker_servo_control_core;
    import dalt_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
    localparam int PHASE_ITEMS = 250;
    localparam int CYCLE_LIMIT = 200000;

    // idling patterns
    localparam int MODE_SEND_LIGHT = 0;
    localparam int MODE_RECV_LIGHT = 1;
    localparam int MODE_NO_IDLE    = 2;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_ready;
    req_t              req = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    result_t           result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    req_t    pending_requests[$];
    result_t predicted_results[$];
    logic    req_taken = 1'b0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    // predictor state
    cfg_t               servo_cfg;
    logic [PULSE_W-1:0] x_pos = X_HOME_RST;
    logic [PULSE_W-1:0] y_pos = Y_HOME_RST;

    dual_axis_light_tracker_servo_control_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int light_gap(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int raise_toward(input int p, input int step, input int hi);
        int n;
        if (p >= hi)
            return p;
        n = p + step;
        return (n > hi) ? hi : n;
    endfunction

    function automatic int lower_toward(input int p, input int step, input int lo);
        int n;
        if (p <= lo)
            return p;
        n = (p > step) ? p - step : 0;
        return (n < lo) ? lo : n;
    endfunction

    function automatic result_t predict_servo(input req_t r);
        result_t            res;
        int                 dx;
        int                 dy;
        int                 step;
        int                 nx;
        int                 ny;
        logic [DELAY_W-1:0] dly;
        nx = x_pos;
        ny = y_pos;
        step = 0;
        dly = DELAY_NONE;
        case (r.opcode) inside
            OP_SAMPLE:
            begin
                dx = light_gap(r.left_light, r.right_light);
                dy = light_gap(r.up_light, r.down_light);
                // band follows the larger of the two differences
                if (dx > BAND_HIGH || dy > BAND_HIGH)
                begin
                    step = STEP_FAST;
                    dly = DELAY_FAST;
                end
                else if (dx > BAND_MID || dy > BAND_MID)
                begin
                    step = STEP_MID;
                    dly = DELAY_MID;
                end
                else
                begin
                    step = STEP_FINE;
                    dly = DELAY_FINE;
                end
                if (dx > servo_cfg.dead_band)
                begin
                    if (r.left_light > r.right_light)
                        nx = raise_toward(nx, step, servo_cfg.x_max_pulse);
                    else if (r.left_light < r.right_light)
                        nx = lower_toward(nx, step, servo_cfg.x_min_pulse);
                end
                if (dy > servo_cfg.dead_band)
                begin
                    if (r.up_light > r.down_light)
                        ny = raise_toward(ny, step, servo_cfg.y_max_pulse);
                    else if (r.up_light < r.down_light)
                        ny = lower_toward(ny, step, servo_cfg.y_min_pulse);
                end
            end
            OP_JOG_X_DN, OP_JOG_X_UP, OP_JOG_Y_DN, OP_JOG_Y_UP:
            begin
                step = servo_cfg.jog_step;
                dly = DELAY_FAST;
                if (r.opcode == OP_JOG_X_DN)
                    nx = lower_toward(nx, step, servo_cfg.x_min_pulse);
                else if (r.opcode == OP_JOG_X_UP)
                    nx = raise_toward(nx, step, servo_cfg.x_max_pulse);
                else if (r.opcode == OP_JOG_Y_DN)
                    ny = lower_toward(ny, step, servo_cfg.y_min_pulse);
                else
                    ny = raise_toward(ny, step, servo_cfg.y_max_pulse);
            end
            OP_HOME:
            begin
                nx = servo_cfg.x_home_pulse;
                ny = servo_cfg.y_home_pulse;
            end
            default: ;
        endcase
        res.x_pulse_out = nx[PULSE_W-1:0];
        res.y_pulse_out = ny[PULSE_W-1:0];
        res.step_used = step[STEP_W-1:0];
        res.delay_code = dly;
        res.x_moved = (res.x_pulse_out != x_pos);
        res.y_moved = (res.y_pulse_out != y_pos);
        res.limit_alarm = (res.x_pulse_out == servo_cfg.x_min_pulse)
                       || (res.x_pulse_out == servo_cfg.x_max_pulse)
                       || (res.y_pulse_out == servo_cfg.y_min_pulse)
                       || (res.y_pulse_out == servo_cfg.y_max_pulse);
        x_pos = res.x_pulse_out;
        y_pos = res.y_pulse_out;
        return res;
    endfunction

    function automatic req_t make_request(input logic [OP_W-1:0] op,
                                          input logic [LIGHT_W-1:0] l,
                                          input logic [LIGHT_W-1:0] r,
                                          input logic [LIGHT_W-1:0] u,
                                          input logic [LIGHT_W-1:0] d);
        return {op, l, r, u, d};
    endfunction

    // pairs of readings whose difference sits on the band and dead-band edges, is zero or is random
    function automatic void light_pair(output logic [LIGHT_W-1:0] a,
                                       output logic [LIGHT_W-1:0] b);
        int gap;
        int base;
        case ($urandom_range(8))
            0: gap = 0;
            1: gap = servo_cfg.dead_band;
            2: gap = servo_cfg.dead_band + 1;
            3: gap = BAND_MID;
            4: gap = BAND_MID + 1;
            5: gap = BAND_HIGH;
            6: gap = BAND_HIGH + 1;
            7: gap = $urandom_range(4095);
            default: gap = -1;
        endcase
        if (gap < 0)
        begin
            a = LIGHT_W'($urandom);
            b = LIGHT_W'($urandom);
        end
        else
        begin
            if (gap > 4095)
                gap = 4095;
            base = $urandom_range(4095 - gap);
            a = LIGHT_W'(base + gap);
            b = LIGHT_W'(base);
            if ($urandom_range(1))
                {a, b} = {b, a};
        end
    endfunction

    function automatic req_t random_request();
        logic [OP_W-1:0]    op;
        logic [LIGHT_W-1:0] l;
        logic [LIGHT_W-1:0] r;
        logic [LIGHT_W-1:0] u;
        logic [LIGHT_W-1:0] d;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 50)
            op = OP_SAMPLE;
        else if (pick < 82)
            op = OP_W'($urandom_range(OP_JOG_Y_UP, OP_JOG_X_DN));
        else if (pick < 92)
            op = OP_HOME;
        else
            op = pick[0] ? OP_SPARE_LO : OP_SPARE_HI;
        light_pair(l, r);
        light_pair(u, d);
        return make_request(op, l, r, u, d);
    endfunction

    function automatic cfg_t make_setup(input int x_lo, input int x_hi, input int y_lo,
                                        input int y_hi, input int x_home, input int y_home,
                                        input int dead, input int jog);
        return {PULSE_W'(x_lo), PULSE_W'(x_hi), PULSE_W'(y_lo), PULSE_W'(y_hi),
                PULSE_W'(x_home), PULSE_W'(y_home), LIGHT_W'(dead), STEP_W'(jog)};
    endfunction

    function automatic cfg_t random_setup();
        return make_setup($urandom_range(5000), $urandom_range(20000),
                          $urandom_range(5000), $urandom_range(20000),
                          $urandom_range(20000), $urandom_range(20000),
                          $urandom_range(600), $urandom_range(2000));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_X_MIN:  servo_cfg.x_min_pulse = value[PULSE_W-1:0];
            REG_X_MAX:  servo_cfg.x_max_pulse = value[PULSE_W-1:0];
            REG_Y_MIN:  servo_cfg.y_min_pulse = value[PULSE_W-1:0];
            REG_Y_MAX:  servo_cfg.y_max_pulse = value[PULSE_W-1:0];
            REG_X_HOME: servo_cfg.x_home_pulse = value[PULSE_W-1:0];
            REG_Y_HOME: servo_cfg.y_home_pulse = value[PULSE_W-1:0];
            REG_DEAD:   servo_cfg.dead_band = value[LIGHT_W-1:0];
            REG_JOG:    servo_cfg.jog_step = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setup(input cfg_t c);
        write_reg(REG_X_MIN, c.x_min_pulse);
        write_reg(REG_X_MAX, c.x_max_pulse);
        write_reg(REG_Y_MIN, c.y_min_pulse);
        write_reg(REG_Y_MAX, c.y_max_pulse);
        write_reg(REG_X_HOME, c.x_home_pulse);
        write_reg(REG_Y_HOME, c.y_home_pulse);
        write_reg(REG_DEAD, c.dead_band);
        write_reg(REG_JOG, c.jog_step);
    endtask

    // checked just after the rising edge, once the monitor has run and req_valid is settled
    task automatic wait_settled();
        while (pending_requests.size() != 0 || req_valid || predicted_results.size() != 0)
        begin
            @(posedge clk);
            #1;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            MODE_SEND_LIGHT:
            begin
                send_idle_pct = 16;
                recv_idle_pct = 51;
            end
            MODE_RECV_LIGHT:
            begin
                send_idle_pct = 51;
                recv_idle_pct = 16;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic run_phase(input int mode, input cfg_t setup);
        wait_settled();
        set_idling(mode);
        apply_setup(setup);
        repeat (PHASE_ITEMS) pending_requests.push_back(random_request());
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_result(input result_t want, input result_t got);
        check_field("x_pulse_out", want.x_pulse_out, got.x_pulse_out);
        check_field("y_pulse_out", want.y_pulse_out, got.y_pulse_out);
        check_field("step_used", want.step_used, got.step_used);
        check_field("delay_code", want.delay_code, got.delay_code);
        check_field("x_moved", want.x_moved, got.x_moved);
        check_field("y_moved", want.y_moved, got.y_moved);
        check_field("limit_alarm", want.limit_alarm, got.limit_alarm);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_valid <= 1'b1;
                    req <= pending_requests.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: results checked against the oldest prediction, new requests predicted
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            req_taken <= req_valid && req_ready;
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result expected none got %h", $time, result);
                end
                else
                    check_result(predicted_results.pop_front(), result);
            end
            if (req_valid && req_ready)
                predicted_results.push_back(predict_servo(req));
        end
    end

    initial
    begin
        servo_cfg = make_setup(X_MIN_RST, X_MAX_RST, Y_MIN_RST, Y_MAX_RST,
                               X_HOME_RST, Y_HOME_RST, DEAD_RST, JOG_RST);
        set_idling(MODE_SEND_LIGHT);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed requests at the reset settings
        pending_requests.push_back(make_request(OP_SAMPLE, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_SAMPLE, 4095, 4095, 4095, 4095));
        pending_requests.push_back(make_request(OP_SAMPLE, 4095, 0, 0, 0));
        pending_requests.push_back(make_request(OP_SAMPLE, 0, 4095, 4095, 0));
        pending_requests.push_back(make_request(OP_SAMPLE, 501, 0, 7, 7));
        pending_requests.push_back(make_request(OP_SAMPLE, 500, 0, 7, 7));
        pending_requests.push_back(make_request(OP_SAMPLE, 0, 201, 0, 0));
        pending_requests.push_back(make_request(OP_SAMPLE, 200, 0, 0, 0));
        pending_requests.push_back(make_request(OP_SAMPLE, 0, 0, 101, 0));
        // difference on the dead band: band values still reported
        pending_requests.push_back(make_request(OP_SAMPLE, 0, 0, 100, 0));
        pending_requests.push_back(make_request(OP_SAMPLE, 9, 9, 0, 501));
        pending_requests.push_back(make_request(OP_SAMPLE, 12'hAAA, 12'h555, 12'h555, 12'hAAA));
        pending_requests.push_back(make_request(OP_JOG_X_DN, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_JOG_X_UP, 4095, 4095, 4095, 4095));
        pending_requests.push_back(make_request(OP_JOG_Y_DN, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_JOG_Y_UP, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_HOME, 4095, 0, 4095, 0));
        pending_requests.push_back(make_request(OP_SPARE_LO, 4095, 0, 0, 4095));
        pending_requests.push_back(make_request(OP_SPARE_HI, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_SAMPLE, 4095, 0, 4095, 0));

        // wide limits, homes on the edges, no dead band
        run_phase(MODE_SEND_LIGHT, make_setup(0, 20000, 0, 20000, 0, 20000, 0, 2000));
        // crossed limits, dead band at its top
        run_phase(MODE_SEND_LIGHT, make_setup(3000, 1000, 2500, 2400, 2000, 100, 4095, 7));
        // full register width
        run_phase(MODE_RECV_LIGHT, make_setup(1, 32767, 0, 32767, 32767, 0, 0, 2047));
        run_phase(MODE_RECV_LIGHT, random_setup());
        // x pinned by equal limits, zero jog step
        run_phase(MODE_NO_IDLE, make_setup(1200, 1200, 500, 2500, 1500, 1000, 4095, 0));
        run_phase(MODE_NO_IDLE, random_setup());

        wait_settled();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
